// ===== rtl/lae_pkg.sv =====
`default_nettype none

package lae_pkg;

    // Level format is unsigned Q0.LEVEL_BITS; full scale is 2^LEVEL_BITS.
    localparam int LEVEL_BITS  = 16;
    localparam int LENGTH_BITS = 20;

    // The quotient of every ramp division is at most full scale, one bit wider than a level.
    localparam int QUOT_BITS    = LEVEL_BITS + 1;
    localparam int PROD_BITS    = LENGTH_BITS + QUOT_BITS;
    localparam int DIV_CNT_BITS = $clog2(QUOT_BITS);

    localparam logic [QUOT_BITS-1:0] ONE_LEVEL = QUOT_BITS'(1) << LEVEL_BITS;

    // Stream payload widths, padded to whole bytes.
    localparam int IN_FIELD_BITS  = 2 + LEVEL_BITS;
    localparam int OUT_FIELD_BITS = LEVEL_BITS + 3 + 1;
    localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

    typedef logic [2:0] stage_t;

    localparam stage_t ST_ATTACK  = 3'd0;
    localparam stage_t ST_DECAY   = 3'd1;
    localparam stage_t ST_SUSTAIN = 3'd2;
    localparam stage_t ST_RELEASE = 3'd3;
    localparam stage_t ST_END     = 3'd4;

    typedef struct packed {
        logic                   enabled;
        logic [LENGTH_BITS-1:0] attack_len;
        logic [LENGTH_BITS-1:0] decay_len;
        logic [LENGTH_BITS-1:0] release_len;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic div_step;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic need_div;
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/lae_ctrl.sv =====
`default_nettype none

module lae_ctrl
    import lae_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  wire logic    out_ready,
    input  wire status_t status,
    output cmd_t         cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_DIVIDE,
        S_DELIVER
    } state_t;

    state_t                  state_reg;
    state_t                  state_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg;
    logic [DIV_CNT_BITS-1:0] cnt_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;

    always_comb
    begin
        cmd.load     = (state_reg == S_IDLE) && in_valid;
        cmd.mul      = (state_reg == S_EVAL);
        cmd.div_step = (state_reg == S_DIVIDE);
        cmd.commit   = (state_reg == S_DELIVER) && (!out_valid_reg || out_ready);
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cnt_next   = '0;
                state_next = status.need_div ? S_DIVIDE : S_DELIVER;
            end
            S_DIVIDE:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_BITS'(QUOT_BITS - 1))
                begin
                    state_next = S_DELIVER;
                end
            end
            S_DELIVER:
            begin
                if (cmd.commit)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/lae_dp.sv =====
`default_nettype none

module lae_dp
    import lae_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cfg_t                  cfg,
    input  wire cmd_t                  cmd,
    output status_t                    status,
    input  wire logic                  retrigger,
    input  wire logic                  release_now,
    input  wire logic [LEVEL_BITS-1:0] sustain_level,
    output logic [LEVEL_BITS-1:0]      level,
    output stage_t                     stage,
    output logic                       finished
);

    // Clamp a quotient of up to full scale into the level range.
    function automatic logic [LEVEL_BITS-1:0] sat_level(input logic [QUOT_BITS-1:0] v);
        sat_level = v[LEVEL_BITS] ? '1 : v[LEVEL_BITS-1:0];
    endfunction

    // Latched input item.
    logic                   retrig_reg;
    logic                   rel_reg;
    logic [LEVEL_BITS-1:0]  sus_reg;

    // Envelope state.
    stage_t                 stage_reg;
    stage_t                 stage_next;
    logic [LENGTH_BITS-1:0] pos_reg;
    logic [LENGTH_BITS-1:0] pos_next;
    logic [LEVEL_BITS-1:0]  held_reg;
    logic [LEVEL_BITS-1:0]  held_next;
    logic                   done_reg;
    logic                   done_next;

    // Multiplier result doubles as the divider's remainder and quotient shift register.
    logic [LENGTH_BITS-1:0] rem_reg;
    logic [QUOT_BITS-1:0]   quo_reg;

    // Output register.
    logic [LEVEL_BITS-1:0]  level_reg;
    logic [LEVEL_BITS-1:0]  level_next;
    stage_t                 ostage_reg;
    stage_t                 ostage_next;
    logic                   fin_reg;
    logic                   fin_next;

    // Working view of the state after retrigger, release request and clamping.
    stage_t                 st_a;
    stage_t                 st_b;
    logic [LENGTH_BITS-1:0] pos_a;
    logic [LENGTH_BITS-1:0] pos_b;
    logic [LENGTH_BITS-1:0] pos_c;
    logic [LENGTH_BITS-1:0] pos_inc;
    logic [LEVEL_BITS-1:0]  held_a;
    logic                   done_a;
    logic                   is_end;
    logic [LENGTH_BITS-1:0] len;
    logic [LENGTH_BITS-1:0] op_a;
    logic [QUOT_BITS-1:0]   op_b;
    logic [PROD_BITS-1:0]   product;
    logic [LENGTH_BITS:0]   rem_sh;
    logic                   rem_ge;
    logic [LEVEL_BITS-1:0]  ramp_level;

    always_comb
    begin
        st_a   = retrig_reg ? ST_ATTACK : stage_reg;
        pos_a  = retrig_reg ? '0 : pos_reg;
        held_a = retrig_reg ? '0 : held_reg;
        done_a = retrig_reg ? 1'b0 : done_reg;
        is_end = (st_a > ST_RELEASE);
        st_b   = rel_reg ? ST_RELEASE : st_a;
        pos_b  = rel_reg ? '0 : pos_a;
        case (st_b)
            ST_ATTACK: len = cfg.attack_len;
            ST_DECAY:  len = cfg.decay_len;
            default:   len = cfg.release_len;
        endcase
        pos_c   = (pos_b > len) ? len : pos_b;
        pos_inc = pos_c + 1'b1;
    end

    always_comb
    begin
        op_a = (st_b == ST_RELEASE) ? (len - pos_c) : pos_c;
        case (st_b)
            ST_ATTACK: op_b = ONE_LEVEL;
            ST_DECAY:  op_b = ONE_LEVEL - QUOT_BITS'(sus_reg);
            default:   op_b = QUOT_BITS'(held_a);
        endcase
        product = PROD_BITS'(op_a) * PROD_BITS'(op_b);
    end

    assign status.need_div = cfg.enabled && !is_end && (st_b != ST_SUSTAIN) && (len != '0);

    // One restoring division step per cycle; the initial remainder is always below len.
    always_comb
    begin
        rem_sh = {rem_reg, quo_reg[QUOT_BITS-1]};
        rem_ge = (rem_sh >= {1'b0, len});
    end

    always_comb
    begin
        case (st_b)
            ST_ATTACK: ramp_level = sat_level(quo_reg);
            ST_DECAY:  ramp_level = sat_level(ONE_LEVEL - quo_reg);
            default:   ramp_level = quo_reg[LEVEL_BITS-1:0];
        endcase
    end

    always_comb
    begin
        stage_next  = stage_reg;
        pos_next    = pos_reg;
        held_next   = held_reg;
        done_next   = done_reg;
        level_next  = '0;
        ostage_next = stage_reg;
        fin_next    = done_reg;
        if (!cfg.enabled)
        begin
            level_next = '0;
        end
        else if (is_end)
        begin
            stage_next  = st_a;
            pos_next    = pos_a;
            held_next   = '0;
            done_next   = 1'b1;
            ostage_next = ST_END;
            fin_next    = 1'b1;
        end
        else if (st_b == ST_SUSTAIN)
        begin
            stage_next  = st_b;
            pos_next    = pos_b;
            held_next   = sus_reg;
            done_next   = done_a;
            level_next  = sus_reg;
            ostage_next = ST_SUSTAIN;
            fin_next    = done_a;
        end
        else
        begin
            if (len == '0)
            begin
                level_next = held_a;
                held_next  = held_a;
            end
            else
            begin
                level_next = ramp_level;
                held_next  = (st_b == ST_RELEASE) ? held_a : ramp_level;
            end
            ostage_next = st_b;
            fin_next    = done_a;
            done_next   = done_a;
            if (pos_inc >= len)
            begin
                pos_next = '0;
                case (st_b)
                    ST_ATTACK: stage_next = ST_DECAY;
                    ST_DECAY:  stage_next = ST_SUSTAIN;
                    default:
                    begin
                        stage_next = ST_END;
                        done_next  = 1'b1;
                    end
                endcase
            end
            else
            begin
                pos_next   = pos_inc;
                stage_next = st_b;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            retrig_reg <= retrigger;
            rel_reg    <= release_now;
            sus_reg    <= sustain_level;
        end
        if (cmd.mul)
        begin
            rem_reg <= product[PROD_BITS-1:QUOT_BITS];
            quo_reg <= product[QUOT_BITS-1:0];
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_ge ? LENGTH_BITS'(rem_sh - {1'b0, len}) : rem_sh[LENGTH_BITS-1:0];
            quo_reg <= {quo_reg[QUOT_BITS-2:0], rem_ge};
        end
        if (cmd.commit)
        begin
            level_reg  <= level_next;
            ostage_reg <= ostage_next;
            fin_reg    <= fin_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= ST_ATTACK;
            pos_reg   <= '0;
            held_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else if (cmd.commit)
        begin
            stage_reg <= stage_next;
            pos_reg   <= pos_next;
            held_reg  <= held_next;
            done_reg  <= done_next;
        end
    end

    assign level    = level_reg;
    assign stage    = ostage_reg;
    assign finished = fin_reg;

endmodule

`default_nettype wire

// ===== rtl/linear_adsr_envelope_unit.sv =====
`default_nettype none

// Linear ADSR envelope generator. Each transaction on the slave stream is one audio
// sample and yields exactly one transaction on the master stream carrying the envelope
// level (unsigned Q0.16), the stage that produced it and the finished flag. Attack ramps
// from zero to full scale, decay falls from full scale to the sustain level, sustain
// follows the sustain input, and release falls linearly from the last held level to zero,
// after which the end stage outputs zero with finished set. Stage lengths are given in
// samples through the configuration channel; a zero length holds the last level for one
// sample. Samples whose level comes from a ramp go from acceptance to the result register
// by latching the sample, a 20x17 multiply, the one-bit-per-cycle restoring divider by
// the stage length, and a write of the result once the output register is free. Disabled,
// end, sustain and zero-length samples skip the divider. A new sample is accepted in the
// cycle after the result is written, even while that result still waits in the output
// register. Configuration writes are taken in any cycle but must only be issued while
// the block is idle.

module linear_adsr_envelope_unit
    import lae_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    // Fields from bit 0: retrigger, release_now, sustain_level[15:0], zero padding.
    input  wire logic [IN_DATA_BITS-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    // Fields from bit 0: level[15:0], stage[2:0], finished, zero padding.
    output logic [OUT_DATA_BITS-1:0]      m_tdata,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [1:0]               cfg_index,
    input  wire logic [LENGTH_BITS-1:0]   cfg_data
);

    // Register indexes of the configuration channel.
    localparam logic [1:0] CFG_ENABLED = 2'd0;
    localparam logic [1:0] CFG_ATTACK  = 2'd1;
    localparam logic [1:0] CFG_DECAY   = 2'd2;
    localparam logic [1:0] CFG_RELEASE = 2'd3;

    cfg_t                  cfg_reg;
    cmd_t                  cmd;
    status_t               status;
    logic [LEVEL_BITS-1:0] level;
    stage_t                stage;
    logic                  finished;

    // The configuration registers accept a write in every cycle.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enabled     <= 1'b1;
            cfg_reg.attack_len  <= LENGTH_BITS'(1440);
            cfg_reg.decay_len   <= LENGTH_BITS'(4800);
            cfg_reg.release_len <= LENGTH_BITS'(9600);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ENABLED: cfg_reg.enabled     <= cfg_data[0];
                CFG_ATTACK:  cfg_reg.attack_len  <= cfg_data;
                CFG_DECAY:   cfg_reg.decay_len   <= cfg_data;
                CFG_RELEASE: cfg_reg.release_len <= cfg_data;
                default:     cfg_reg             <= cfg_reg;
            endcase
        end
    end

    // The sequencer owns both handshakes and steps the datapath through each sample.
    lae_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    // The datapath holds the envelope state, the multiplier, the divider and the result.
    lae_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .cmd           (cmd),
        .status        (status),
        .retrigger     (s_tdata[0]),
        .release_now   (s_tdata[1]),
        .sustain_level (s_tdata[LEVEL_BITS+1:2]),
        .level         (level),
        .stage         (stage),
        .finished      (finished)
    );

    assign m_tdata = OUT_DATA_BITS'({finished, stage, level});

endmodule

`default_nettype wire
